>>> design/dcgt_pkg.sv
`timescale 1ns / 1ps

package dcgt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 16;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned TIME_W   = 63;
   localparam int unsigned GRACE_W  = 32;
   localparam int unsigned ACTION_W = 2;

   localparam logic [GRACE_W-1:0] GRACE_RESET = 32'd10000;

   // Request tdata: ip_addr, now_ms, then zero padding to a whole byte.
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CHECK  = 2'd0,
      ACT_FORGET = 2'd1,
      ACT_RECENT = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

>>> design/duplicate_claim_grace_table.sv
`timescale 1ns / 1ps

// Table of IPv4 addresses with the time each was first seen. A request
// transaction carries the action in req_tuser (check and record, forget,
// or seen recently) and the address and current time in req_tdata; each
// request yields exactly one response transaction with a one-bit answer.
// The table lives in two RAMs, for addresses and times, read one entry per
// cycle; a request keeps the block busy from acceptance until the whole
// table is scanned, less when a matching entry ends the scan early. The
// response is held in its own register, so the next request is taken while
// it waits; if that response is still waiting when the next scan ends, the
// block holds until it is taken. Reset marks all entries free at once
// through per-entry valid bits; no clearing pass runs. The grace period is
// to be written through the csr channel only while idle; the block itself
// does not enforce this.
module duplicate_claim_grace_table #(
   parameter int unsigned TABLE_ENTRIES = dcgt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] ip_addr, [94:32] now_ms, [95] zero
   input  logic [dcgt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [dcgt_pkg::ACTION_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] answer, [7:1] zero
   output logic [dcgt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dcgt_pkg::GRACE_W-1:0]    csr_data
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int unsigned ADDR_W = dcgt_pkg::ADDR_W;
   localparam int unsigned TIME_W = dcgt_pkg::TIME_W;

   dcgt_pkg::state_type    state_ff, state_in;
   dcgt_pkg::action_type   act_ff, act_in;
   logic [ADDR_W-1:0]      ip_ff, ip_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [dcgt_pkg::GRACE_W-1:0] grace_ff, grace_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   issue_ff, issue_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   answer_ff, answer_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_answer_ff, rsp_answer_in;

   logic                   addr_wr_en;
   logic                   time_wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic [ADDR_W-1:0]      addr_wr_data;
   logic [ADDR_W-1:0]      addr_rd;
   logic [TIME_W-1:0]      time_rd;

   logic                   entry_valid;
   logic [ADDR_W-1:0]      entry_addr;
   logic [TIME_W-1:0]      entry_time;
   logic [TIME_W:0]        elapsed;
   logic                   grace_met;
   logic                   match;
   logic                   entry_free;
   logic                   finish;

   dcgt_ram #(
      .WIDTH(ADDR_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_addr_ram (
      .clock  (clock),
      .wr_en  (addr_wr_en),
      .wr_addr(wr_idx),
      .wr_data(addr_wr_data),
      .rd_addr(idx_ff),
      .rd_data(addr_rd)
   );

   dcgt_ram #(
      .WIDTH(TIME_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_time_ram (
      .clock  (clock),
      .wr_en  (time_wr_en),
      .wr_addr(wr_idx),
      .wr_data(now_ff),
      .rd_addr(idx_ff),
      .rd_data(time_rd)
   );

   // An entry that was never written reads as free with a zero time.
   assign entry_valid = valid_ff[cmp_idx_ff];
   assign entry_addr  = entry_valid ? addr_rd : '0;
   assign entry_time  = entry_valid ? time_rd : '0;
   assign elapsed     = {1'b0, now_ff} - {1'b0, entry_time};
   assign grace_met   = !elapsed[TIME_W] &&
                        (elapsed[TIME_W-1:0] >= {(TIME_W - dcgt_pkg::GRACE_W)'(0), grace_ff});
   assign match       = (entry_addr == ip_ff);
   assign entry_free  = (entry_addr == '0);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      ip_in         = ip_ff;
      now_in        = now_ff;
      grace_in      = grace_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      answer_in     = answer_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_answer_in = rsp_answer_ff;
      addr_wr_en    = 1'b0;
      time_wr_en    = 1'b0;
      wr_idx        = cmp_idx_ff;
      addr_wr_data  = '0;
      finish        = 1'b0;

      if (csr_valid) begin
         grace_in = csr_data;
      end

      unique case (state_ff)
         dcgt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               act_in        = dcgt_pkg::action_type'(req_tuser);
               ip_in         = req_tdata[ADDR_W-1:0];
               now_in        = req_tdata[ADDR_W+TIME_W-1:ADDR_W];
               idx_in        = '0;
               issue_in      = 1'b1;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               answer_in     = 1'b0;
               state_in      = dcgt_pkg::ST_SCAN;
            end
         end
         dcgt_pkg::ST_SCAN: begin
            // Reads are issued one entry ahead of the compare.
            if (issue_ff) begin
               cmp_idx_in = idx_ff;
               cmp_vld_in = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (cmp_vld_ff) begin
               case (act_ff)
                  dcgt_pkg::ACT_CHECK: begin
                     if (match) begin
                        answer_in = grace_met;
                        finish    = 1'b1;
                     end else if (entry_free && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = cmp_idx_ff;
                     end
                  end
                  dcgt_pkg::ACT_FORGET: begin
                     if (match) begin
                        addr_wr_en   = 1'b1;
                        addr_wr_data = '0;
                        finish       = 1'b1;
                     end
                  end
                  dcgt_pkg::ACT_RECENT: begin
                     if (match && !grace_met) begin
                        answer_in = 1'b1;
                        finish    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (!finish && cmp_idx_ff == LAST_IDX) begin
                  finish = 1'b1;
                  // A new address goes into the lowest free entry, if any.
                  if (act_ff == dcgt_pkg::ACT_CHECK && free_found_in) begin
                     addr_wr_en       = 1'b1;
                     time_wr_en       = 1'b1;
                     wr_idx           = free_idx_in;
                     addr_wr_data     = ip_ff;
                     valid_in[wr_idx] = 1'b1;
                  end
               end
            end
            if (finish) begin
               issue_in   = 1'b0;
               cmp_vld_in = 1'b0;
               state_in   = dcgt_pkg::ST_DONE;
            end
         end
         dcgt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = answer_ff;
               state_in      = dcgt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcgt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcgt_pkg::ST_IDLE;
         grace_ff     <= dcgt_pkg::GRACE_RESET;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grace_ff     <= grace_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      ip_ff         <= ip_in;
      now_ff        <= now_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      answer_ff     <= answer_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   assign req_tready = (state_ff == dcgt_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(dcgt_pkg::RSP_DATA_W - 1)'(0), rsp_answer_ff};
   assign csr_ready  = 1'b1;

`ifndef SYNTHESIS
   // Once a request is taken, req_tready drops as its scan starts.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a scan was starting");

   // Recording an address makes that entry valid.
   a_record_sets_valid: assert property (@(posedge clock) disable iff (reset)
      time_wr_en |=> valid_ff[$past(wr_idx)])
      else $error("recorded entry not marked valid");

   // A forget never answers one.
   a_forget_answers_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dcgt_pkg::ST_DONE) && (act_ff == dcgt_pkg::ACT_FORGET) |-> !answer_ff)
      else $error("forget produced a nonzero answer");

   // Only a check records a time, and only as the last step of a scan.
   a_time_write_ends_scan: assert property (@(posedge clock) disable iff (reset)
      time_wr_en |=> (state_ff == dcgt_pkg::ST_DONE) && (act_ff == dcgt_pkg::ACT_CHECK))
      else $error("time written outside the end of a check scan");
`endif

endmodule

>>> design/dcgt_ram.sv
`timescale 1ns / 1ps

module dcgt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
